@@ sv/pbd_pkg.sv @@
// Shared types and constants of the pulse beat detector.
`timescale 1ns / 1ps
`default_nettype none

package pbd_pkg;

  typedef logic [15:0] ms_t;
  typedef logic [11:0] level_t;
  typedef logic [9:0]  sample_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY_MIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LEVEL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MINUTE_UNITS    = 3'd4;

  localparam logic [7:0] SAMPLE_STEP_RST     = 8'd2;
  localparam ms_t        REFRACTORY_MIN_RST  = 16'd250;
  localparam ms_t        SILENCE_TIMEOUT_RST = 16'd2500;
  localparam sample_t    IDLE_LEVEL_RST      = 10'd512;
  localparam ms_t        MINUTE_UNITS_RST    = 16'd60000;

  localparam ms_t    BEAT_INTERVAL_RST = 16'd600;
  localparam level_t PEAK_RST          = 12'd0;
  localparam level_t TROUGH_RST        = 12'd512;
  localparam level_t THRESHOLD_RST     = 12'd256;

  // x / 5 == (x * RECIP5) >> RECIP5_SHIFT for every 16-bit x
  localparam logic [15:0] RECIP5       = 16'd52429;
  localparam int          RECIP5_SHIFT = 18;

  localparam int OUT_W = 40;

endpackage

`default_nettype wire

@@ sv/pulse_beat_detector_core.sv @@
// Pulse beat detector core: beat detection and BPM estimation per sensor sample.
//
// Input stream s_*: one 10-bit sensor sample per request in s_tdata[9:0].
// Output stream m_*: one result per sample: bpm, sticky bpm_ready, beat_now,
// pulse_high and the last interval, packed in m_tdata.
// Configuration: cfg_wen writes cfg_data to register cfg_index (0 sample_step,
// 1 refractory_min, 2 silence_timeout, 3 idle_level, 4 minute_units); other
// indexes are ignored. Write only while the block is idle.
// A sample without a counted beat passes S_GATE and S_EVAL to S_OUT, which writes
// the output register. A beat that updates the BPM also passes S_MEAN and
// S_DIV_BPM: the mean interval comes from a reciprocal multiply and the one
// restoring divider runs SUM_W steps for minute_units / mean.
// s_tready is high only while no sample is in work, so a new sample is taken
// only once the previous one has left S_OUT; the output register lets the
// next sample in while the previous result still waits.
// A stalled receiver holds m_tdata; a finished sample waits in the last step
// until the output register frees up.
// Reset (rst, synchronous) restores the configuration registers, m_tvalid and the
// detector state to their defaults and holds s_tready low; the interval history
// needs no clearing, it is seeded on the second beat before any read.
`timescale 1ns / 1ps
`default_nettype none

module pulse_beat_detector_core
  import pbd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [15:0]           s_tdata,   // [9:0] sample, [15:10] zero
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_W-1:0]           m_tdata    // [15:0] bpm, [16] bpm_ready,
                                                // [17] beat_now, [18] pulse_high,
                                                // [34:19] interval_ms, [39:35] zero
);

  localparam int SUM_W = $clog2(HISTORY_DEPTH * 65535 + 1);
  localparam int CNT_W = $clog2(SUM_W + 1);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(SUM_W - 1);
  // sum / HISTORY_DEPTH == (sum * MEAN_MUL) >> MEAN_SH for every SUM_W-bit sum
  localparam int     MEAN_SH    = SUM_W + $clog2(HISTORY_DEPTH);
  localparam longint MEAN_RECIP = ((longint'(1) << MEAN_SH) + longint'(HISTORY_DEPTH) - 1)
                                  / longint'(HISTORY_DEPTH);
  localparam logic [SUM_W:0] MEAN_MUL = (SUM_W+1)'(MEAN_RECIP);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GATE,
    S_EVAL,
    S_MEAN,
    S_DIV_BPM,
    S_OUT
  } state_t;

  state_t state;

  logic [7:0] sample_step;
  ms_t        refractory_min;
  ms_t        silence_timeout;
  sample_t    idle_level;
  ms_t        minute_units;

  ms_t        elapsed;
  ms_t        beat_interval;
  ms_t        hist [HISTORY_DEPTH];
  logic [SUM_W-1:0] hist_sum;
  level_t     peak_level;
  level_t     trough_level;
  level_t     threshold;
  logic       pulse_flag;
  logic       first_beat;
  logic       second_beat;
  ms_t        bpm_value;
  logic       ready_flag;

  sample_t    sample_r;
  ms_t        n_r;
  logic [13:0] q5;
  logic       beat_r;

  logic [16:0]      div_rem;
  logic [SUM_W-1:0] div_quo;
  ms_t              div_den;
  logic [CNT_W-1:0] div_cnt;

  logic [16:0]  elapsed_sum;
  ms_t          n_next;
  logic [31:0]  recip_prod;
  ms_t          gate;
  level_t       s_ext;
  logic         below_thr;
  logic         above_thr;
  level_t       peak_upd;
  level_t       trough_upd;
  logic         beat_cond;
  logic         timeout;
  logic         fall;
  logic signed [12:0] amp;
  logic signed [12:0] amp_half;
  logic [12:0]  new_thr;
  logic [SUM_W-1:0] hist_sum_next;
  logic         first_hit;
  logic         pulse_eval;
  logic         first_eval;
  logic         second_eval;
  ms_t          elapsed_eval;
  level_t       peak_eval;
  level_t       trough_eval;
  level_t       thr_eval;
  logic [2*SUM_W:0] mean_prod;
  ms_t          mean_val;
  logic [16:0]  div_trial;
  logic         div_ge;
  logic [16:0]  div_rem_next;
  logic [SUM_W-1:0] div_quo_next;

  assign s_tready = (state == S_IDLE) && !rst;

  always_comb begin
    elapsed_sum = {1'b0, elapsed} + {9'b0, sample_step};
    n_next      = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];
    recip_prod  = beat_interval * RECIP5;
    gate        = {2'b0, q5} + {1'b0, q5, 1'b0};
    s_ext       = {2'b0, sample_r};
    below_thr   = s_ext < threshold;
    above_thr   = s_ext > threshold;
    trough_upd  = (below_thr && (n_r > gate) && (s_ext < trough_level)) ? s_ext : trough_level;
    peak_upd    = (above_thr && (s_ext > peak_level)) ? s_ext : peak_level;
    beat_cond   = (n_r > refractory_min) && above_thr && !pulse_flag && (n_r > gate);
    timeout     = n_r > silence_timeout;
    fall        = below_thr && pulse_flag;
    amp         = $signed({1'b0, peak_upd}) - $signed({1'b0, trough_upd});
    // halve with truncation toward zero
    amp_half    = (amp + $signed({12'b0, amp[12]})) >>> 1;
    new_thr     = {1'b0, trough_upd} + 13'(amp_half);
    hist_sum_next = second_beat ? (SUM_W'(n_r) * DEPTH_SUM)
                                : (hist_sum - SUM_W'(hist[0]) + SUM_W'(n_r));
  end

  // detector state after one sample; a first beat takes precedence over the timeout
  always_comb begin
    first_hit    = beat_cond && first_beat;
    elapsed_eval = (beat_cond || timeout) ? '0 : n_r;
    pulse_eval   = beat_cond ? 1'b1 : (fall ? 1'b0 : pulse_flag);
    first_eval   = first_hit ? 1'b0 : (timeout ? 1'b1 : first_beat);
    second_eval  = first_hit ? 1'b1 : ((beat_cond || timeout) ? 1'b0 : second_beat);
    peak_eval    = peak_upd;
    trough_eval  = trough_upd;
    thr_eval     = threshold;
    if (fall) begin
      peak_eval   = new_thr[11:0];
      trough_eval = new_thr[11:0];
      thr_eval    = new_thr[11:0];
    end
    if (timeout && !first_hit) begin
      peak_eval   = {2'b0, idle_level};
      trough_eval = {2'b0, idle_level};
      thr_eval    = {2'b0, idle_level};
    end
  end

  always_comb begin
    mean_prod = hist_sum * MEAN_MUL;
    mean_val  = mean_prod[MEAN_SH +: 16];
  end

  // restoring divider step; a zero divisor yields all ones
  always_comb begin
    div_trial    = {div_rem[15:0], div_quo[SUM_W-1]};
    div_ge       = div_trial >= {1'b0, div_den};
    div_rem_next = div_ge ? (div_trial - {1'b0, div_den}) : div_trial;
    div_quo_next = {div_quo[SUM_W-2:0], div_ge};
  end

  always_ff @(posedge clk) begin
    if ((state == S_EVAL) && beat_cond && !first_beat) begin
      for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
        hist[k] <= second_beat ? n_r : hist[k+1];
      end
      hist[HISTORY_DEPTH-1] <= n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      sample_step     <= SAMPLE_STEP_RST;
      refractory_min  <= REFRACTORY_MIN_RST;
      silence_timeout <= SILENCE_TIMEOUT_RST;
      idle_level      <= IDLE_LEVEL_RST;
      minute_units    <= MINUTE_UNITS_RST;
      elapsed         <= '0;
      beat_interval   <= BEAT_INTERVAL_RST;
      peak_level      <= PEAK_RST;
      trough_level    <= TROUGH_RST;
      threshold       <= THRESHOLD_RST;
      pulse_flag      <= 1'b0;
      first_beat      <= 1'b1;
      second_beat     <= 1'b0;
      bpm_value       <= '0;
      ready_flag      <= 1'b0;
      m_tvalid        <= 1'b0;
      div_cnt         <= '0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_SAMPLE_STEP:     sample_step     <= cfg_data[7:0];
          REG_REFRACTORY_MIN:  refractory_min  <= cfg_data;
          REG_SILENCE_TIMEOUT: silence_timeout <= cfg_data;
          REG_IDLE_LEVEL:      idle_level      <= cfg_data[9:0];
          REG_MINUTE_UNITS:    minute_units    <= cfg_data;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            sample_r <= s_tdata[9:0];
            n_r      <= n_next;
            state    <= S_GATE;
          end
        end
        S_GATE: begin
          q5    <= recip_prod[RECIP5_SHIFT +: 14];
          state <= S_EVAL;
        end
        S_EVAL: begin
          beat_r       <= beat_cond;
          peak_level   <= peak_eval;
          trough_level <= trough_eval;
          threshold    <= thr_eval;
          elapsed      <= elapsed_eval;
          pulse_flag   <= pulse_eval;
          first_beat   <= first_eval;
          second_beat  <= second_eval;
          if (beat_cond) begin
            beat_interval <= n_r;
          end
          if (beat_cond && !first_beat) begin
            hist_sum <= hist_sum_next;
            state    <= S_MEAN;
          end else begin
            state <= S_OUT;
          end
        end
        S_MEAN: begin
          div_quo <= SUM_W'(minute_units);
          div_den <= mean_val;
          div_rem <= '0;
          div_cnt <= '0;
          state   <= S_DIV_BPM;
        end
        S_DIV_BPM: begin
          div_rem <= div_rem_next;
          div_quo <= div_quo_next;
          if (div_cnt == DIV_LAST) begin
            bpm_value  <= div_quo_next[15:0];
            ready_flag <= 1'b1;
            div_cnt    <= '0;
            state      <= S_OUT;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'b0, beat_interval, pulse_flag, beat_r, ready_flag, bpm_value};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_sticky: assert property (@(posedge clk) disable iff (rst)
    ready_flag |=> ready_flag)
    else $error("bpm ready flag dropped");

  a_beat_flags: assert property (@(posedge clk) disable iff (rst)
    !(first_beat && second_beat))
    else $error("first and second beat both pending");

  a_beat_restart: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) && beat_cond |=> (elapsed == 16'd0) && pulse_flag)
    else $error("beat did not restart elapsed time");

  a_beat_pulse: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[17] |-> m_tdata[18])
    else $error("beat reported without pulse high");
`endif

endmodule

`default_nettype wire
